FILE: hw/rtl/quaternion_from_two_vectors_core_assert.svh
// ----------------------------------------------------------------------------
// quaternion from two vectors - assertion macros
// clocked property checks used by the rtl of the block
// ----------------------------------------------------------------------------
`ifndef QUATERNION_FROM_TWO_VECTORS_CORE_ASSERT_SVH
`define QUATERNION_FROM_TWO_VECTORS_CORE_ASSERT_SVH

// check while out of reset
`define QFTV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also holds during reset
`define QFTV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/qftv_pkg.sv
// ----------------------------------------------------------------------------
// qftv_pkg
// widths, codes and step functions of the shortest arc quaternion block
// ----------------------------------------------------------------------------
package qftv_pkg;

  localparam int unsigned FracBitsIn = 12;
  localparam int unsigned InW        = 16;
  localparam int unsigned InDataW    = 6 * InW;
  localparam int unsigned OutW       = 16;
  localparam int unsigned OutDataW   = 4 * OutW;
  localparam int unsigned Q14One     = 16384;
  localparam logic signed [33:0] DotOne = 34'sd1 <<< (2 * FracBitsIn);

  localparam int unsigned Sqrt1Steps = 32;
  localparam int unsigned Sqrt2Steps = 31;
  localparam int unsigned DivSteps   = 15;

  typedef enum logic [1:0] {
    OUT_COMPUTED  = 2'd0,
    OUT_UNIT_DOT  = 2'd1,
    OUT_ZERO_NORM = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } sq_t;

  typedef struct packed {
    logic signed [33:0] dot;
    logic signed [32:0] crs_x;
    logic signed [32:0] crs_y;
    logic signed [32:0] crs_z;
    outcome_e           code;
  } side1_t;

  typedef struct packed {
    logic [3:0] neg;
    outcome_e   code;
  } side2_t;

  // one digit of the bitwise integer square root
  function automatic sq_t sqrt_step(sq_t s, logic [63:0] b);
    sq_t         o;
    logic [63:0] t;
    t = s.r + b;
    if (s.v >= t) begin
      o.v = s.v - t;
      o.r = (s.r >> 1) + b;
    end else begin
      o.v = s.v;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  function automatic logic [32:0] abs33(logic signed [32:0] c);
    return c[32] ? 33'(-c) : 33'(c);
  endfunction

  // leading zeros of a byte, all-zero byte gives don't care
  function automatic logic [2:0] lz8(logic [7:0] x);
    logic [2:0] n;
    n = 3'd0;
    for (int k = 0; k < 8; k++) begin
      if (x[k]) n = 3'(7 - k);
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/quaternion_from_two_vectors_core.sv
// ----------------------------------------------------------------------------
// quaternion_from_two_vectors_core
// shortest arc unit quaternion from two q3.12 vectors, fully pipelined
// ----------------------------------------------------------------------------
// usage:
// - input beat on s_axis: six signed q3.12 components, first vector then second
// - output beat on m_axis: quaternion x, y, z, w in signed q1.14 and an
//   outcome code in tuser (computed, dot exactly plus or minus one, zero norm)
// - one beat accepted per cycle while the output is not stalled; every input
//   beat gives one output beat, in order
// - the pipeline is 3 product/sum stages, a 32 stage square root for
//   |a|*|b|, 6 stages of magnitude, normalizing shift and squares, a sum
//   stage and a 31 stage square root for the norm, a numerator stage and a
//   15 stage restoring divider per lane, and the output register; the rate
//   is set by the fact that every stage is one step deep
// - when m_axis_tready is low with a result waiting, the whole pipeline
//   holds and s_axis_tready drops in the same cycle; nothing is lost
// - reset clears all valid bits; the first beat may be sent right after it
// ----------------------------------------------------------------------------
module quaternion_from_two_vectors_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z (16 bits each)
  input  logic [qftv_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // quat_x, quat_y, quat_z, quat_w (16 bits each)
  output logic [qftv_pkg::OutDataW-1:0]  m_axis_tdata,
  // outcome (2 bits)
  output logic [1:0]                     m_axis_tuser
);
  import qftv_pkg::*;
  `include "quaternion_from_two_vectors_core_assert.svh"

  // global advance: the pipeline moves unless a result is stuck at the output
  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: all products
  logic signed [15:0] ax, ay, az, bx, by, bz;
  assign ax = s_axis_tdata[15:0];
  assign ay = s_axis_tdata[31:16];
  assign az = s_axis_tdata[47:32];
  assign bx = s_axis_tdata[63:48];
  assign by = s_axis_tdata[79:64];
  assign bz = s_axis_tdata[95:80];

  logic               p1_vld_q;
  logic signed [31:0] p1_dot_q [3];
  logic signed [31:0] p1_crs_q [6];
  logic signed [31:0] p1_sq_q  [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_dot_q[0] <= ax * bx;
      p1_dot_q[1] <= ay * by;
      p1_dot_q[2] <= az * bz;
      p1_crs_q[0] <= ay * bz;
      p1_crs_q[1] <= by * az;
      p1_crs_q[2] <= az * bx;
      p1_crs_q[3] <= bz * ax;
      p1_crs_q[4] <= ax * by;
      p1_crs_q[5] <= bx * ay;
      p1_sq_q[0]  <= ax * ax;
      p1_sq_q[1]  <= ay * ay;
      p1_sq_q[2]  <= az * az;
      p1_sq_q[3]  <= bx * bx;
      p1_sq_q[4]  <= by * by;
      p1_sq_q[5]  <= bz * bz;
    end
  end

  // stage 2: dot, cross and squared norms
  logic               p2_vld_q;
  logic signed [33:0] p2_dot_q;
  logic signed [32:0] p2_crs_q [3];
  logic [31:0]        p2_na_q, p2_nb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else if (en) begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_dot_q    <= 34'(p1_dot_q[0]) + 34'(p1_dot_q[1]) + 34'(p1_dot_q[2]);
      p2_crs_q[0] <= 33'(p1_crs_q[0]) - 33'(p1_crs_q[1]);
      p2_crs_q[1] <= 33'(p1_crs_q[2]) - 33'(p1_crs_q[3]);
      p2_crs_q[2] <= 33'(p1_crs_q[4]) - 33'(p1_crs_q[5]);
      p2_na_q     <= $unsigned(p1_sq_q[0]) + $unsigned(p1_sq_q[1]) + $unsigned(p1_sq_q[2]);
      p2_nb_q     <= $unsigned(p1_sq_q[3]) + $unsigned(p1_sq_q[4]) + $unsigned(p1_sq_q[5]);
    end
  end

  // stage 3: product of squared norms, unit dot detection
  logic   sq1_vld_q [Sqrt1Steps+1];
  sq_t    sq1_q     [Sqrt1Steps+1];
  side1_t side1_q   [Sqrt1Steps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq1_vld_q[0] <= 1'b0;
    end else if (en) begin
      sq1_vld_q[0] <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq1_q[0].v         <= p2_na_q * p2_nb_q;
      sq1_q[0].r         <= '0;
      side1_q[0].dot     <= p2_dot_q;
      side1_q[0].crs_x   <= p2_crs_q[0];
      side1_q[0].crs_y   <= p2_crs_q[1];
      side1_q[0].crs_z   <= p2_crs_q[2];
      side1_q[0].code    <= (p2_dot_q == DotOne || p2_dot_q == -DotOne) ? OUT_UNIT_DOT
                                                                       : OUT_COMPUTED;
    end
  end

  // |a|*|b| square root, one result bit per stage
  for (genvar j = 0; j < Sqrt1Steps; j++) begin : g_sqrt1
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * j);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq1_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        sq1_vld_q[j+1] <= sq1_vld_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq1_q[j+1]   <= sqrt_step(sq1_q[j], Bit);
        side1_q[j+1] <= side1_q[j];
      end
    end
  end

  // stage a: scalar part and sign/magnitude split
  logic        a_vld_q;
  logic [32:0] a_mag_q [4];
  logic [3:0]  a_neg_q;
  outcome_e    a_code_q;
  logic signed [33:0] w_sum;
  side1_t      s1e;
  assign s1e   = side1_q[Sqrt1Steps];
  assign w_sum = $signed({2'b00, sq1_q[Sqrt1Steps].r[31:0]}) + s1e.dot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= sq1_vld_q[Sqrt1Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_mag_q[0] <= abs33(s1e.crs_x);
      a_mag_q[1] <= abs33(s1e.crs_y);
      a_mag_q[2] <= abs33(s1e.crs_z);
      a_mag_q[3] <= w_sum[32:0];  // never negative
      a_neg_q    <= {1'b0, s1e.crs_z[32], s1e.crs_y[32], s1e.crs_x[32]};
      a_code_q   <= s1e.code;
    end
  end

  // stage b: or of magnitudes has the leading one of the largest
  logic        b_vld_q;
  logic [32:0] b_mag_q [4];
  logic [32:0] b_or_q;
  logic [3:0]  b_neg_q;
  outcome_e    b_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_mag_q  <= a_mag_q;
      b_or_q   <= a_mag_q[0] | a_mag_q[1] | a_mag_q[2] | a_mag_q[3];
      b_neg_q  <= a_neg_q;
      b_code_q <= a_code_q;
    end
  end

  // stage c: per byte leading zeros, zero norm detection
  logic        c_vld_q;
  logic [32:0] c_mag_q [4];
  logic [4:0]  c_nz_q;
  logic [2:0]  c_lz_q [5];
  logic [3:0]  c_neg_q;
  outcome_e    c_code_q;
  logic [39:0] b_pad;
  assign b_pad = {b_or_q, 7'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int g = 0; g < 5; g++) begin
        c_nz_q[g] <= |b_pad[39-8*g -: 8];
        c_lz_q[g] <= lz8(b_pad[39-8*g -: 8]);
      end
      c_mag_q  <= b_mag_q;
      c_neg_q  <= b_neg_q;
      c_code_q <= (b_code_q == OUT_COMPUTED && b_or_q == '0) ? OUT_ZERO_NORM : b_code_q;
    end
  end

  // stage d: total leading zero count
  logic        d_vld_q;
  logic [32:0] d_mag_q [4];
  logic [5:0]  d_lz_q;
  logic [3:0]  d_neg_q;
  outcome_e    d_code_q;
  logic [5:0]  lz_d;

  always_comb begin
    lz_d = '0;
    for (int g = 4; g >= 0; g--) begin
      if (c_nz_q[g]) lz_d = 6'(8 * g) + 6'(c_lz_q[g]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_mag_q  <= c_mag_q;
      d_lz_q   <= lz_d;
      d_neg_q  <= c_neg_q;
      d_code_q <= c_code_q;
    end
  end

  // stage e: common shift, largest lands in [2^29, 2^30), truncating
  logic        e_vld_q;
  logic [29:0] e_m_q [4];
  logic [3:0]  e_neg_q;
  outcome_e    e_code_q;
  logic [32:0] shl [4];

  always_comb begin
    for (int i = 0; i < 4; i++) shl[i] = d_mag_q[i] << d_lz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en) begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) e_m_q[i] <= shl[i][32:3];
      e_neg_q  <= d_neg_q;
      e_code_q <= d_code_q;
    end
  end

  // stage f: squares
  logic        f_vld_q;
  logic [29:0] f_m_q  [4];
  logic [59:0] f_sq_q [4];
  logic [3:0]  f_neg_q;
  outcome_e    f_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) f_sq_q[i] <= e_m_q[i] * e_m_q[i];
      f_m_q    <= e_m_q;
      f_neg_q  <= e_neg_q;
      f_code_q <= e_code_q;
    end
  end

  // stage g: sum of squares feeds the norm square root
  logic        sq2_vld_q [Sqrt2Steps+1];
  sq_t         sq2_q     [Sqrt2Steps+1];
  logic [29:0] sq2_m_q   [Sqrt2Steps+1][4];
  side2_t      side2_q   [Sqrt2Steps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq2_vld_q[0] <= 1'b0;
    end else if (en) begin
      sq2_vld_q[0] <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq2_q[0].v        <= 64'(f_sq_q[0]) + 64'(f_sq_q[1]) + 64'(f_sq_q[2]) + 64'(f_sq_q[3]);
      sq2_q[0].r        <= '0;
      sq2_m_q[0]        <= f_m_q;
      side2_q[0].neg    <= f_neg_q;
      side2_q[0].code   <= f_code_q;
    end
  end

  for (genvar j = 0; j < Sqrt2Steps; j++) begin : g_sqrt2
    localparam logic [63:0] Bit = 64'd1 << (60 - 2 * j);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq2_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        sq2_vld_q[j+1] <= sq2_vld_q[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq2_q[j+1]   <= sqrt_step(sq2_q[j], Bit);
        sq2_m_q[j+1] <= sq2_m_q[j];
        side2_q[j+1] <= side2_q[j];
      end
    end
  end

  // stage h: rounded numerators, then restoring divide per lane
  logic        dv_vld_q [DivSteps+1];
  logic [44:0] dv_rem_q [DivSteps+1][4];
  logic [14:0] dv_quo_q [DivSteps+1][4];
  logic [30:0] dv_den_q [DivSteps+1];
  side2_t      dv_side_q [DivSteps+1];
  logic [30:0] norm_n;
  assign norm_n = sq2_q[Sqrt2Steps].r[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (en) begin
      dv_vld_q[0] <= sq2_vld_q[Sqrt2Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        dv_rem_q[0][i] <= {1'b0, sq2_m_q[Sqrt2Steps][i], 14'd0} + 45'(norm_n >> 1);
        dv_quo_q[0][i] <= '0;
      end
      dv_den_q[0]  <= norm_n;
      dv_side_q[0] <= side2_q[Sqrt2Steps];
    end
  end

  for (genvar t = 0; t < DivSteps; t++) begin : g_div
    localparam int unsigned Sh = DivSteps - 1 - t;
    logic [45:0] dsh;
    assign dsh = 46'(dv_den_q[t]) << Sh;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[t+1] <= 1'b0;
      end else if (en) begin
        dv_vld_q[t+1] <= dv_vld_q[t];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int i = 0; i < 4; i++) begin
          if ({1'b0, dv_rem_q[t][i]} >= dsh) begin
            dv_rem_q[t+1][i] <= 45'({1'b0, dv_rem_q[t][i]} - dsh);
            dv_quo_q[t+1][i] <= dv_quo_q[t][i] | (15'd1 << Sh);
          end else begin
            dv_rem_q[t+1][i] <= dv_rem_q[t][i];
            dv_quo_q[t+1][i] <= dv_quo_q[t][i];
          end
        end
        dv_den_q[t+1]  <= dv_den_q[t];
        dv_side_q[t+1] <= dv_side_q[t];
      end
    end
  end

  // output register: sign applied, identity for the special cases
  logic [OutDataW-1:0] out_data_q;
  outcome_e            out_code_q;
  logic [OutDataW-1:0] out_data_d;
  side2_t              s2e;
  assign s2e = dv_side_q[DivSteps];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      out_data_d[16*i +: 16] = s2e.neg[i] ? 16'(-{1'b0, dv_quo_q[DivSteps][i]})
                                          : {1'b0, dv_quo_q[DivSteps][i]};
    end
    if (s2e.code != OUT_COMPUTED) begin
      out_data_d = {16'(Q14One), 48'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_code_q <= s2e.code;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_code_q;

  // special outcomes always carry the identity quaternion
  `QFTV_ASSERT(a_ident, m_axis_tvalid && m_axis_tuser != OUT_COMPUTED |-> m_axis_tdata == {16'(Q14One), 48'd0}, "special outcome without identity")
  // scalar part of a computed result is in [0, 1.0]
  `QFTV_ASSERT(a_w_range, m_axis_tvalid && m_axis_tuser == OUT_COMPUTED |-> !m_axis_tdata[63] && m_axis_tdata[63:48] <= 16'(Q14One), "scalar part out of range")
  // a stalled pipeline takes no input
  `QFTV_ASSERT(a_stall, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while output stalled")
  // nothing comes out during reset
  `QFTV_ASSERT_RST(a_rst, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

endmodule
